// ----- design/heart_rate_and_rhythm_check_core_macros.svh -----
// assertion macros for the heart rate and rhythm check core
`ifndef HEART_RATE_AND_RHYTHM_CHECK_CORE_MACROS_SVH
`define HEART_RATE_AND_RHYTHM_CHECK_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HRRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HRRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HRRC_ASSERT(lbl, prop, msg)
`define HRRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/hrrc_pkg.sv -----
// shared types and constants of the heart rate and rhythm check core
package hrrc_pkg;

  localparam int MAX_PEAKS_DEF = 8;

  localparam int POS_W      = 11;
  localparam int RATE_W     = 12;
  localparam int WLEN_W     = 11;
  localparam int BPM_W      = 18;
  localparam int STAT_W     = 2;
  localparam int IV_W       = 12;
  localparam int GAP_W      = 13;
  localparam int PAIR_W     = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 12;
  localparam int DIVIDEND_W = 18;
  localparam int DIVISOR_W  = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd2;

  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST   = 12'd250;
  localparam logic [RATE_W-1:0] FALLBACK_RATE_RST = 12'd340;
  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST = 11'd1300;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FEW  = 2'd1,
    STAT_ZERO = 2'd2
  } hrrc_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV_AVG,
    S_DIV_BPM,
    S_IRR,
    S_WALK,
    S_OUT
  } hrrc_state_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } hrrc_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hrrc_div_sts_t;

endpackage

// ----- design/hrrc_if.sv -----
// valid/ready channels carrying peak beats in and result beats out
interface hrrc_in_if import hrrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] peak_position;
  logic             last_peak;

  modport source (output valid, output peak_position, output last_peak, input ready);
  modport sink (input valid, input peak_position, input last_peak, output ready);
endinterface

interface hrrc_out_if import hrrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BPM_W-1:0]  beats_per_minute;
  logic              irregular;
  logic [STAT_W-1:0] status;

  modport source (output valid, output beats_per_minute, output irregular, output status,
                  input ready);
  modport sink (input valid, input beats_per_minute, input irregular, input status,
                output ready);
endinterface

// ----- design/heart_rate_and_rhythm_check_core.sv -----
// heart rate and rhythm check: top level with sequencer, peak store and rhythm walk
//
// Peak positions of one capture window arrive on in_i, one beat per peak, in
// ascending order; the beat with last_peak closes the window. out_o gives one
// result beat per window: beats per minute, an irregular-rhythm flag and a status.
// A peak that is not last is taken at once. After the last peak the block
// drops in_i.ready and runs its sequencer: a decision state, up to two passes
// of the shared restoring divider (one quotient bit per cycle over an 18-bit
// dividend), a carry check, and for 3 to MaxPeaks peaks with no pending carry
// a walk over the peak store, one read per cycle. Results wait in an output
// register; when the receiver stalls, the block still takes the peaks of the
// next window and holds its next result in the sequencer until the register
// frees up. Reset clears the count, the carry state and the registers to
// their defaults (250, 340, 1300); the peak store needs no clearing.
// Configuration is written through cfg_we_i; the user must write it only
// while idle, as the block itself does not enforce this.
`include "heart_rate_and_rhythm_check_core_macros.svh"

module heart_rate_and_rhythm_check_core import hrrc_pkg::*; #(
  parameter int MaxPeaks = MAX_PEAKS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hrrc_in_if.sink              in_i,
  hrrc_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int CntW  = $clog2(MaxPeaks + 2);
  localparam int AddrW = $clog2(MaxPeaks);

  function automatic logic pair_irr(input logic signed [PAIR_W-1:0] a,
                                    input logic signed [PAIR_W-1:0] b);
    logic signed [PAIR_W:0]   d;
    logic signed [PAIR_W:0]   lo;
    logic signed [PAIR_W+3:0] d5;
    d  = (a > b) ? ((PAIR_W+1)'(a) - (PAIR_W+1)'(b)) : ((PAIR_W+1)'(b) - (PAIR_W+1)'(a));
    lo = (a > b) ? (PAIR_W+1)'(b) : (PAIR_W+1)'(a);
    d5 = ((PAIR_W+4)'(d) <<< 2) + (PAIR_W+4)'(d);
    return (a != b) && (d5 > (PAIR_W+4)'(lo));
  endfunction

  hrrc_state_e state_q, state_d;

  logic [RATE_W-1:0] sample_rate_q;
  logic [RATE_W-1:0] fallback_rate_q;
  logic [WLEN_W-1:0] window_length_q;

  logic [POS_W-1:0] peak_mem [MaxPeaks];
  logic [POS_W-1:0] rd_data_q;

  logic [CntW-1:0]  count_q;
  logic [POS_W-1:0] first_q;
  logic [POS_W-1:0] last_q;
  logic [POS_W-1:0] prev_q;

  logic                    carry_q;
  logic signed [IV_W-1:0]  carried_iv_q;
  logic [POS_W-1:0]        carried_last_q;
  logic signed [GAP_W-1:0] gap_q;

  logic [BPM_W-1:0] bpm_q;
  logic             irr_q;
  hrrc_status_e     stat_q;

  logic [CntW-1:0]        ptr_q;
  logic [CntW-1:0]        rd_idx_q;
  logic                   rd_vld_q;
  logic [POS_W-1:0]       b_q;
  logic signed [IV_W-1:0] iv_q;

  logic             out_valid_q;
  logic [BPM_W-1:0] out_bpm_q;
  logic             out_irr_q;
  hrrc_status_e     out_stat_q;

  hrrc_div_req_t         div_req;
  hrrc_div_sts_t         div_sts;
  logic [DIVIDEND_W-1:0] div_quo;

  logic                    in_acc;
  logic [CntW-1:0]         count_inc;
  logic                    n_lt2;
  logic                    n_eq2;
  logic                    n_le_max;
  logic [POS_W-1:0]        nm1;
  logic signed [IV_W-1:0]  diff_avg;
  logic signed [IV_W-1:0]  diff_last;
  logic                    avg_ok;
  logic                    last_ok;
  logic [BPM_W-1:0]        num_sr;
  logic [BPM_W-1:0]        num_fb;
  logic signed [GAP_W-1:0] gap_d;
  logic                    issue;
  logic signed [IV_W-1:0]  later;
  logic                    walk_irr;
  logic                    out_load;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // count saturates one above the store depth
  assign count_inc = (count_q == CntW'(MaxPeaks + 1)) ? count_q : count_q + CntW'(1);
  assign n_lt2     = count_q < CntW'(2);
  assign n_eq2     = count_q == CntW'(2);
  assign n_le_max  = count_q <= CntW'(MaxPeaks);
  assign nm1       = POS_W'(count_q - CntW'(1));

  assign diff_avg  = $signed({1'b0, last_q}) - $signed({1'b0, first_q});
  assign diff_last = $signed({1'b0, last_q}) - $signed({1'b0, prev_q});
  // truncating average is positive only when the span reaches count-1
  assign avg_ok    = !diff_avg[IV_W-1] && (diff_avg[POS_W-1:0] >= nm1);
  assign last_ok   = !diff_last[IV_W-1] && (diff_last[POS_W-1:0] != '0);

  // 60 * rate as 64 * rate - 4 * rate
  assign num_sr = BPM_W'({sample_rate_q, 6'b0}) - BPM_W'({sample_rate_q, 2'b0});
  assign num_fb = BPM_W'({fallback_rate_q, 6'b0}) - BPM_W'({fallback_rate_q, 2'b0});

  assign gap_d = $signed({2'b00, first_q}) + $signed({2'b00, window_length_q})
               - $signed({2'b00, carried_last_q});

  assign issue    = (state_q == S_WALK) && (ptr_q < count_q);
  assign later    = $signed({1'b0, rd_data_q}) - $signed({1'b0, b_q});
  assign walk_irr = rd_vld_q && (rd_idx_q >= CntW'(2))
                 && pair_irr(PAIR_W'(later), PAIR_W'(iv_q));

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  hrrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts),
    .quo_o  (div_quo)
  );

  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.last_peak) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (n_lt2) begin
          state_d = S_OUT;
        end else if (n_le_max) begin
          if (avg_ok) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVIDEND_W'(diff_avg[POS_W-1:0]);
            div_req.divisor  = DIVISOR_W'(nm1);
            state_d          = S_DIV_AVG;
          end else begin
            state_d = S_IRR;
          end
        end else if (last_ok) begin
          div_req.start    = 1'b1;
          div_req.dividend = num_fb;
          div_req.divisor  = DIVISOR_W'(diff_last[POS_W-1:0]);
          state_d          = S_DIV_BPM;
        end else begin
          state_d = S_IRR;
        end
      end
      S_DIV_AVG: begin
        if (div_sts.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = num_sr;
          div_req.divisor  = div_quo[DIVISOR_W-1:0];
          state_d          = S_DIV_BPM;
        end
      end
      S_DIV_BPM: begin
        if (div_sts.done) state_d = S_IRR;
      end
      S_IRR: begin
        if (carry_q || n_eq2 || !n_le_max) state_d = S_OUT;
        else state_d = S_WALK;
      end
      S_WALK: begin
        if (!issue && !rd_vld_q) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      sample_rate_q   <= SAMPLE_RATE_RST;
      fallback_rate_q <= FALLBACK_RATE_RST;
      window_length_q <= WINDOW_LENGTH_RST;
      count_q         <= '0;
      carry_q         <= 1'b0;
      carried_iv_q    <= '0;
      carried_last_q  <= '0;
      rd_vld_q        <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SAMPLE_RATE:   sample_rate_q   <= cfg_wdata_i[RATE_W-1:0];
          CFG_FALLBACK_RATE: fallback_rate_q <= cfg_wdata_i[RATE_W-1:0];
          CFG_WINDOW_LENGTH: window_length_q <= cfg_wdata_i[WLEN_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) count_q <= count_inc;
      else if (out_load) count_q <= '0;

      // a pending carry is consumed by the next window of two or more peaks
      if (state_q == S_IRR) begin
        if (carry_q) begin
          carry_q <= 1'b0;
        end else if (n_eq2) begin
          carry_q        <= 1'b1;
          carried_iv_q   <= diff_avg;
          carried_last_q <= last_q;
        end
      end

      if (out_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (count_q < CntW'(MaxPeaks)) peak_mem[count_q[AddrW-1:0]] <= in_i.peak_position;
      if (count_q == '0) first_q <= in_i.peak_position;
      prev_q <= last_q;
      last_q <= in_i.peak_position;
    end

    if (issue) begin
      rd_data_q <= peak_mem[ptr_q[AddrW-1:0]];
      rd_idx_q  <= ptr_q;
      ptr_q     <= ptr_q + CntW'(1);
    end

    if (state_q == S_DECIDE) begin
      gap_q <= gap_d;
      bpm_q <= '0;
      irr_q <= 1'b0;
      if (n_lt2) stat_q <= STAT_FEW;
      else if (n_le_max ? avg_ok : last_ok) stat_q <= STAT_OK;
      else stat_q <= STAT_ZERO;
    end

    if (state_q == S_DIV_BPM && div_sts.done) bpm_q <= div_quo;

    if (state_q == S_IRR) begin
      ptr_q <= CntW'(1);
      b_q   <= first_q;
      if (carry_q) irr_q <= pair_irr(PAIR_W'(carried_iv_q), PAIR_W'(gap_q));
    end

    // each returned entry closes one interval; pairs start with the second
    if (rd_vld_q) begin
      b_q  <= rd_data_q;
      iv_q <= later;
      if (walk_irr) irr_q <= 1'b1;
    end

    if (out_load) begin
      out_bpm_q  <= bpm_q;
      out_irr_q  <= irr_q;
      out_stat_q <= stat_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.beats_per_minute = out_bpm_q;
  assign out_o.irregular        = out_irr_q;
  assign out_o.status           = out_stat_q;

  `HRRC_ASSERT(a_div_idle, (state_q == S_IDLE) |-> !div_sts.busy, "divider busy while idle")
  `HRRC_ASSERT(a_div_done, div_sts.done |-> (state_q == S_DIV_AVG || state_q == S_DIV_BPM),
               "divider result outside a divide step")
  `HRRC_ASSERT(a_err_bpm, (out_valid_q && out_stat_q != STAT_OK) |-> (out_bpm_q == '0),
               "nonzero rate with error status")
  `HRRC_ASSERT(a_count_sat, count_q <= CntW'(MaxPeaks + 1), "peak count past saturation")
  `HRRC_ASSERT_NEXT(a_out_load, out_load, out_valid_q && count_q == '0,
                    "result not posted or count not cleared")

endmodule

// ----- design/hrrc_div.sv -----
// restoring divider, one quotient bit per cycle
module hrrc_div import hrrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hrrc_div_req_t         req_i,
  output hrrc_div_sts_t         sts_o,
  output logic [DIVIDEND_W-1:0] quo_o
);

  localparam int CntW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  dvs_q;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  trial;
  logic                  fits;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = !trial[DIVISOR_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule
